>>> design/pdpd_pkg.sv
// shared types, constants and decode helpers for the pixel detector packet decoder
package pdpd_pkg;

  localparam int WordWidth   = 64;
  localparam int CountWidth  = 13;
  localparam int RefWidth    = 30;
  localparam int OutWidth    = 112;

  localparam logic [7:0] HdrT      = 8'h54;
  localparam logic [7:0] HdrP      = 8'h50;
  localparam logic [7:0] HdrX      = 8'h58;
  localparam logic [7:0] TopTdc    = 8'h6F;
  localparam logic [3:0] TopHit    = 4'hB;
  localparam logic [9:0] SingleOfs = 10'd260;
  localparam logic [9:0] FarEdge   = 10'd515;
  localparam logic [9:0] MidEdge   = 10'd255;

  typedef enum logic [1:0] {
    LAYOUT_SINGLE = 2'd0,
    LAYOUT_DOUBLE = 2'd1,
    LAYOUT_TRIPLE = 2'd2,
    LAYOUT_QUAD   = 2'd3
  } layout_t;

  typedef struct packed {
    logic [29:0] extended_time;
    logic [31:0] flight_time;
    logic [3:0]  arrival_fine;
    logic [13:0] arrival_coarse;
    logic [9:0]  time_over_threshold;
    logic [9:0]  hit_y;
    logic [9:0]  hit_x;
  } hit_t;

  // layout code from header byte 4
  function automatic layout_t layout_of(input logic [7:0] b4);
    layout_t l;
    unique case (b4)
      8'd0:    l = LAYOUT_SINGLE;
      8'd1:    l = LAYOUT_DOUBLE;
      8'd2:    l = LAYOUT_TRIPLE;
      default: l = LAYOUT_QUAD;
    endcase
    return l;
  endfunction

  // full hit decode from one packet word and the current state
  function automatic hit_t decode_hit(input logic [WordWidth-1:0] w,
                                      input layout_t layout,
                                      input logic [RefWidth-1:0] ref_time);
    hit_t        h;
    logic [15:0] a;
    logic [9:0]  x0;
    logic [9:0]  y0;
    a  = w[59:44];
    x0 = {2'b00, a[15:9], a[2]};
    y0 = {2'b00, a[8:3], a[1:0]};
    h.time_over_threshold = w[29:20];
    h.arrival_coarse      = w[43:30];
    h.arrival_fine        = w[19:16];
    h.extended_time       = {w[15:0], w[43:30]};
    h.flight_time         = {2'b00, w[15:0], w[43:30]} - {2'b00, ref_time};
    unique case (layout)
      LAYOUT_SINGLE: begin
        h.hit_x = x0 + SingleOfs;
        h.hit_y = y0;
      end
      LAYOUT_DOUBLE: begin
        h.hit_x = FarEdge - x0;
        h.hit_y = FarEdge - y0;
      end
      LAYOUT_TRIPLE: begin
        h.hit_x = MidEdge - x0;
        h.hit_y = FarEdge - y0;
      end
      default: begin
        h.hit_x = x0;
        h.hit_y = y0;
      end
    endcase
    return h;
  endfunction

endpackage

>>> design/pixel_detector_packet_decoder.sv
// top level: chunked hit packet decoder with a two-deep result buffer
//
// one 64-bit stream word is taken per cycle while s_tready is high, and every
// word is decoded in the cycle it is accepted, so a word can follow in every
// cycle. chunk state (words left, layout, reference time) updates at the
// accepting edge; a hit is written at that edge to the output register (and is
// offered in the next cycle) or, while that one holds an untaken hit, to the skid.
// a skid register behind the output register lets the input keep flowing
// while one hit waits to be taken; s_tready drops only while both hold a hit.
// only hit words inside a chunk produce an output beat; headers, reference
// time words and anything else are consumed silently.
module pixel_detector_packet_decoder
  import pdpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input stream: packet_word
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [WordWidth-1:0] s_tdata,
  // output stream, low bit up: hit_x, hit_y, time_over_threshold,
  // arrival_coarse, arrival_fine, flight_time, extended_time, 2 pad zeros
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutWidth-1:0]  m_tdata
);

  // chunk state
  logic [CountWidth-1:0] words_left;
  logic [CountWidth-1:0] words_left_next;
  layout_t               layout_mode;
  layout_t               layout_mode_next;
  logic [RefWidth-1:0]   tdc_value;
  logic [RefWidth-1:0]   tdc_value_next;

  // result buffer
  hit_t out_hit;
  hit_t out_hit_next;
  logic out_valid;
  logic out_valid_next;
  hit_t skid_hit;
  hit_t skid_hit_next;
  logic skid_valid;
  logic skid_valid_next;

  logic       accept;
  logic       take;
  logic       is_header;
  logic       res_valid;
  hit_t       res_hit;
  logic [7:0] top;

  assign accept    = s_tvalid && s_tready;
  assign take      = out_valid && m_tready;
  assign top       = s_tdata[63:56];
  assign is_header = (s_tdata[7:0] == HdrT) && (s_tdata[15:8] == HdrP) &&
                     (s_tdata[23:16] == HdrX);
  assign res_hit   = decode_hit(s_tdata, layout_mode, tdc_value);
  // a hit counts only inside a chunk
  assign res_valid = accept && (words_left != '0) && (top[7:4] == TopHit);

  // chunk tracking
  always_comb begin
    words_left_next  = words_left;
    layout_mode_next = layout_mode;
    tdc_value_next   = tdc_value;
    if (accept) begin
      if (words_left == '0) begin
        if (is_header) begin
          layout_mode_next = layout_of(s_tdata[39:32]);
          // bytes 7:6 as a 16-bit size, shifted right by 3
          words_left_next  = s_tdata[63:51];
        end
      end else begin
        words_left_next = words_left - CountWidth'(1);
        if (top == TopTdc) begin
          tdc_value_next = s_tdata[41:12];
        end
      end
    end
  end

  // output register with skid stage behind it
  always_comb begin
    out_hit_next    = out_hit;
    out_valid_next  = out_valid;
    skid_hit_next   = skid_hit;
    skid_valid_next = skid_valid;
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_hit_next    = skid_hit;
        out_valid_next  = 1'b1;
        skid_hit_next   = res_hit;
        skid_valid_next = res_valid;
      end else begin
        out_hit_next    = res_hit;
        out_valid_next  = res_valid;
      end
    end else if (res_valid) begin
      // output held, skid is empty because the beat was accepted
      skid_hit_next   = res_hit;
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_left  <= '0;
      layout_mode <= LAYOUT_SINGLE;
      tdc_value   <= '0;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      words_left  <= words_left_next;
      layout_mode <= layout_mode_next;
      tdc_value   <= tdc_value_next;
      out_valid   <= out_valid_next;
      skid_valid  <= skid_valid_next;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_hit  <= out_hit_next;
    skid_hit <= skid_hit_next;
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_hit};

endmodule

>>> tb/sv/pixel_detector_packet_decoder_test.sv
// self-checking stream testbench for the pixel detector packet decoder
module pixel_detector_packet_decoder_test;
  import pdpd_pkg::*;

  // gdc words only burn a chunk count
  localparam logic [3:0] TopGdc = 4'h4;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  tot;
    logic [13:0] coarse;
    logic [3:0]  fine;
    logic [31:0] tof;
    logic [29:0] ext;
  } hit_fields_t;

  // tracks chunk state beside the dut and holds the hits it still owes us
  class hit_ledger;
    hit_fields_t pending_hits[$];
    logic [12:0] words_left;
    layout_t     layout;
    logic [29:0] ref_time;
    int          errors;

    function new();
      words_left = '0;
      layout     = LAYOUT_SINGLE;
      ref_time   = '0;
      errors     = 0;
    endfunction

    // one accepted input beat
    function void take_word(logic [63:0] w);
      hit_fields_t h;
      logic [15:0] a;
      int unsigned x0, y0, xs, ys;
      logic [31:0] ext;
      if (words_left == '0) begin
        if (w[7:0] == HdrT && w[15:8] == HdrP && w[23:16] == HdrX) begin
          layout     = (w[39:32] <= 8'd2) ? layout_t'(w[33:32]) : LAYOUT_QUAD;
          words_left = w[63:51];
        end
        return;
      end
      words_left = words_left - 13'd1;
      if (w[63:56] == TopTdc) begin
        ref_time = w[41:12];
        return;
      end
      if (w[63:60] != TopHit) return;
      a  = w[59:44];
      x0 = ((a & 16'hFE00) >> 8) + ((a & 16'h0007) >> 2);
      y0 = ((a & 16'h01F8) >> 1) + (a & 16'h0003);
      case (layout)
        LAYOUT_SINGLE: begin
          xs = x0 + SingleOfs;
          ys = y0;
        end
        LAYOUT_DOUBLE: begin
          xs = FarEdge - x0;
          ys = FarEdge - y0;
        end
        LAYOUT_TRIPLE: begin
          xs = MidEdge - x0;
          ys = FarEdge - y0;
        end
        default: begin
          xs = x0;
          ys = y0;
        end
      endcase
      ext      = (32'(w[15:0]) * 32'd16384 + 32'(w[43:30])) & 32'h3FFF_FFFF;
      h.x      = xs[9:0];
      h.y      = ys[9:0];
      h.tot    = w[29:20];
      h.coarse = w[43:30];
      h.fine   = w[19:16];
      h.ext    = ext[29:0];
      h.tof    = ext - 32'(ref_time);
      pending_hits.insert(pending_hits.size(), h);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted output beat, fields from the low bit up
    function void check_hit(logic [OutWidth-1:0] d);
      hit_fields_t h;
      if (pending_hits.size() == 0) begin
        $error("hit beat with no hit pending: %h", d);
        errors++;
        return;
      end
      h = pending_hits.pop_front();
      compare("hit_x", 32'(h.x), 32'(d[9:0]));
      compare("hit_y", 32'(h.y), 32'(d[19:10]));
      compare("time_over_threshold", 32'(h.tot), 32'(d[29:20]));
      compare("arrival_coarse", 32'(h.coarse), 32'(d[43:30]));
      compare("arrival_fine", 32'(h.fine), 32'(d[47:44]));
      compare("flight_time", h.tof, d[79:48]);
      compare("extended_time", 32'(h.ext), 32'(d[109:80]));
      compare("pad", 32'd0, 32'(d[111:110]));
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WordWidth-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutWidth-1:0]  m_tdata;

  // set during one long stretch: both sides run without idling
  bit        calm = 1'b0;
  hit_ledger ledger = new();

  pixel_detector_packet_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // result side: random back-pressure, every taken beat goes to the ledger
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) ledger.check_hit(m_tdata);
    m_tready <= calm || ($urandom_range(99) >= 38);
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [63:0] header_word(logic [7:0] layout_byte, logic [12:0] count);
    return {count, 3'($urandom), 8'($urandom), layout_byte, 8'($urandom), HdrX, HdrP, HdrT};
  endfunction

  function automatic logic [63:0] hit_word(logic [15:0] addr, logic [13:0] toa,
                                           logic [9:0] tot, logic [3:0] fine,
                                           logic [15:0] spider);
    return {TopHit, addr, toa, tot, fine, spider};
  endfunction

  function automatic logic [63:0] tdc_word(logic [29:0] t);
    return {TopTdc, 14'($urandom), t, 12'($urandom)};
  endfunction

  // legal layouts most of the time, out-of-range bytes the rest
  function automatic logic [7:0] pick_layout();
    int k;
    k = $urandom_range(0, 5);
    if (k < 4) return 8'(k);
    return 8'($urandom_range(4, 255));
  endfunction

  function automatic logic [63:0] chunk_word();
    int k;
    k = $urandom_range(99);
    if (k < 60) return {TopHit, 60'({$urandom, $urandom})};
    if (k < 75) return tdc_word(30'($urandom));
    if (k < 85) return {TopGdc, 60'({$urandom, $urandom})};
    if (k < 90) return header_word(pick_layout(), 13'($urandom));
    return {$urandom, $urandom};
  endfunction

  // outside a chunk: junk, stray hits, and near-miss headers
  function automatic logic [63:0] stray_word();
    int k;
    k = $urandom_range(0, 2);
    if (k == 0) return {$urandom, $urandom};
    if (k == 1) return {TopHit, 60'({$urandom, $urandom})};
    return {40'({$urandom, $urandom}), HdrX ^ 8'(1 << $urandom_range(0, 7)), HdrP, HdrT};
  endfunction

  // one input beat with a random gap in front
  task automatic send_word(logic [63:0] w);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.take_word(w);
  endtask

  // hold the input off until every hit owed has come out
  task automatic wait_for_hits();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.pending_hits.size() != 0);
  endtask

  initial begin
    int  decoded_words;
    int  n;
    bit  drained;
    decoded_words = 0;
    drained       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a hit before any header is skipped
    send_word(hit_word('1, '1, '1, '1, '1));
    // single layout, hits before any reference time use zero
    send_word(header_word(8'd0, 13'd4));
    send_word(hit_word(16'h0000, 14'h0000, 10'h000, 4'h0, 16'h0000));
    send_word(hit_word(16'hFFFF, 14'h3FFF, 10'h3FF, 4'hF, 16'hFFFF));
    send_word(tdc_word(30'h3FFF_FFFF));
    // small time minus max reference wraps
    send_word(hit_word(16'h0007, 14'h0001, 10'h155, 4'h5, 16'h0000));
    // double layout, corners, gdc word uses up a count
    send_word(header_word(8'd1, 13'd3));
    send_word(hit_word(16'hFFFF, 14'h2AAA, 10'h2AA, 4'hA, 16'hAAAA));
    send_word(hit_word(16'h0000, 14'h1555, 10'h155, 4'h5, 16'h5555));
    send_word({TopGdc, 60'({$urandom, $urandom})});
    // triple layout, header inside a chunk is just a word
    send_word(header_word(8'd2, 13'd3));
    send_word(hit_word(16'hFE07, 14'h0100, 10'h001, 4'h1, 16'h8000));
    send_word(header_word(8'd1, 13'd5));
    send_word(tdc_word(30'h0));
    // empty chunk still picks quad, next word is outside again
    send_word(header_word(8'hFF, 13'd0));
    send_word(hit_word(16'h1234, 14'h0042, 10'h042, 4'h2, 16'h0042));
    // top-bit layout byte maps to quad
    send_word(header_word(8'h80, 13'd2));
    send_word(hit_word(16'hFFFF, 14'h3FFF, 10'h3FF, 4'hF, 16'hFFFF));
    send_word(hit_word(16'h01FB, 14'h0000, 10'h000, 4'h0, 16'h0001));
    send_word(header_word(8'd3, 13'd1));
    send_word(hit_word(16'($urandom), 14'($urandom), 10'($urandom), 4'($urandom),
                       16'($urandom)));
    wait_for_hits();

    // mostly well-formed chunks with random content, some noise between
    while (decoded_words < 1250) begin
      calm = (decoded_words >= 500 && decoded_words < 750);
      if (!drained && decoded_words >= 1000) begin
        wait_for_hits();
        drained = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) send_word(stray_word());
      end
      n = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 63);
      send_word(header_word(pick_layout(), 13'(n)));
      repeat (n) send_word(chunk_word());
      decoded_words += n + 1;
    end
    calm = 1'b0;

    wait_for_hits();
    repeat (8) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
